/* design/vfpd_pkg.sv */
package vfpd_pkg;

  localparam int POS_W      = 24;
  localparam int INV_W      = 26;
  localparam int PROD_W     = POS_W + INV_W + 1;
  localparam int FRAC_SHIFT = 26;
  localparam int Q_W        = PROD_W - FRAC_SHIFT;
  localparam int KEPT_OUT_W = 10;
  localparam int EPOCH_W    = 8;

  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_LEAF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEPT = 1'd1;

  localparam logic [INV_W-1:0] INV_LEAF_MAX = 26'd65536000;
  localparam logic [INV_W-1:0] INV_LEAF_RST = 26'd655360;
  localparam int               MAX_KEPT_RST = 512;

  localparam logic [2:0][31:0] PRIMES = {32'd83492791, 32'd19349663, 32'd73856093};

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    finite;
    logic                    cloud_last;
  } in_t;

  typedef struct packed {
    logic                    keep;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic [KEPT_OUT_W-1:0]   kept_so_far;
    logic                    table_full;
    logic                    cloud_end;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

/* design/vfpd_table.sv */
module vfpd_table #(
  parameter int SLOTS  = 1024,
  parameter int DATA_W = 71
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/vfpd_quant.sv */
module vfpd_quant #(
  parameter int TABLE_SLOTS = 1024,
  parameter int KEY_BITS    = 21
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [vfpd_pkg::POS_W-1:0] pos_x,
  input  logic signed [vfpd_pkg::POS_W-1:0] pos_y,
  input  logic signed [vfpd_pkg::POS_W-1:0] pos_z,
  input  logic [vfpd_pkg::INV_W-1:0]     inv_leaf,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot,
  output logic [3*KEY_BITS-1:0]          key
);

  import vfpd_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam logic signed [Q_W-1:0] KHI = Q_W'((1 << (KEY_BITS - 1)) - 1);
  localparam logic signed [Q_W-1:0] KLO = Q_W'(-(1 << (KEY_BITS - 1)));

  logic [2:0][POS_W-1:0]    pos;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [Q_W-1:0]    qv [3];
  logic [KEY_BITS-1:0]      ksat [3];
  logic [KEY_BITS-1:0]      key_r [3];
  logic [31:0]              hm_r [3];
  logic [31:0]              h_r;
  logic                     va_r, vb_r, vc_r;

  assign pos = {pos_z, pos_y, pos_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[i] = prod_r[i][PROD_W-1:FRAC_SHIFT];
      if (qv[i] > KHI) begin
        ksat[i] = KHI[KEY_BITS-1:0];
      end else if (qv[i] < KLO) begin
        ksat[i] = KLO[KEY_BITS-1:0];
      end else begin
        ksat[i] = qv[i][KEY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        prod_r[i] <= $signed(pos[i]) * $signed({1'b0, inv_leaf});
      end
      if (va_r) begin
        key_r[i] <= ksat[i];
        hm_r[i]  <= {{(32 - KEY_BITS){ksat[i][KEY_BITS-1]}}, ksat[i]} * PRIMES[i];
      end
    end
    if (vb_r) begin
      h_r <= hm_r[0] ^ hm_r[1] ^ hm_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= start;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  assign key = {key_r[2], key_r[1], key_r[0]};

  if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_mask
    assign slot = h_r[SLOT_W-1:0];
    assign done = vc_r;
  end else begin : g_recip
    localparam int              RSH   = 32 + SLOT_W;
    localparam longint unsigned RECIP = (longint'(1) << RSH) / longint'(TABLE_SLOTS);
    localparam logic [32:0]     RCP_M = 33'(RECIP);
    localparam logic [31:0]     NMOD  = 32'(TABLE_SLOTS);
    logic [64:0]       mq_r;
    logic [31:0]       hs_r, qn_r, diff;
    logic [SLOT_W-1:0] rem_r;
    logic              d1_r, d2_r, d3_r;

    assign diff = hs_r - qn_r;

    always_ff @(posedge clk) begin
      if (vc_r) begin
        hs_r <= h_r;
        mq_r <= 65'(h_r) * 65'(RCP_M);
      end
      if (d1_r) begin
        qn_r <= 32'(mq_r[64:RSH] * NMOD);
      end
      if (d2_r) begin
        rem_r <= (diff >= NMOD) ? SLOT_W'(diff - NMOD) : SLOT_W'(diff);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_r <= 1'b0;
        d2_r <= 1'b0;
        d3_r <= 1'b0;
      end else begin
        d1_r <= vc_r;
        d2_r <= d1_r;
        d3_r <= d2_r;
      end
    end

    assign slot = rem_r;
    assign done = d3_r;
  end

endmodule

/* design/voxel_first_point_downsampler_core.sv */
// Voxel first-point downsampler: one point per transfer in, one result per point out, in
// order. Each point is quantized to a voxel (three 24x27 multipliers, then three 32-bit hash
// multipliers), hashed to a start slot and looked up in a single-port-read, single-port-write
// table of TABLE_SLOTS entries by linear probing, one slot per cycle through the registered
// memory read. A finite point whose voxel is new and below the kept limit is passed. A point
// is quantized and hashed to its start slot, then probes P slots, P from 1 to TABLE_SLOTS; a
// non-finite or over-limit point skips the hash and the probe. When TABLE_SLOTS is not a power
// of two, the slot reduction uses a registered reciprocal multiply and one correcting subtract.
// Table occupancy is tagged with an 8-bit cloud epoch, so ending a cloud costs nothing, but
// after reset and after every 255th cloud the block sweeps the whole table, writing every
// slot with in_stall high; configuration writes are taken at any time and must be done only
// while the block is idle.
module voxel_first_point_downsampler_core #(
  parameter int TABLE_SLOTS    = 1024,
  parameter int MAX_KEPT_LIMIT = 512,
  parameter int KEY_BITS       = 21
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vfpd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vfpd_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vfpd_pkg::CFG_W-1:0]      cfg_data
);

  import vfpd_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = 3 * KEY_BITS;
  localparam int ENT_W  = EPOCH_W + KEY_W;
  localparam int KC_W   = $clog2(MAX_KEPT_LIMIT + 1);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
  localparam logic [KC_W-1:0]    LIM_RST   =
    KC_W'((MAX_KEPT_LIMIT < MAX_KEPT_RST) ? MAX_KEPT_LIMIT : MAX_KEPT_RST);

  state_t              state_r, state_nxt;
  logic [INV_W-1:0]    inv_leaf_r, inv_wr;
  logic [KC_W-1:0]     lim_r, lim_wr;
  logic [KC_W-1:0]     kept_count_r;
  logic [EPOCH_W-1:0]  epoch_r;
  in_t                 item_r;
  logic                keep_r, full_r;
  logic [SLOT_W-1:0]   cur_r, cnt_r, clr_r, nxt_slot;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r;
  logic [31:0]         kc_ext;

  logic                q_start, q_done;
  logic [SLOT_W-1:0]   q_slot;
  logic [KEY_W-1:0]    q_key;

  logic                rd_en, wr_en;
  logic [SLOT_W-1:0]   rd_addr, wr_addr;
  logic [ENT_W-1:0]    rd_data, wr_data;

  logic [EPOCH_W-1:0]  ent_tag;
  logic [KEY_W-1:0]    ent_key;
  logic                slot_free, key_hit, probe_last, resolve;
  logic                skip, out_free, load_out, clr_last;
  logic [KEPT_OUT_W-1:0] mk;

  vfpd_quant #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_start),
    .pos_x    (in_data.pos_x),
    .pos_y    (in_data.pos_y),
    .pos_z    (in_data.pos_z),
    .inv_leaf (inv_leaf_r),
    .done     (q_done),
    .slot     (q_slot),
    .key      (q_key)
  );

  vfpd_table #(
    .SLOTS  (TABLE_SLOTS),
    .DATA_W (ENT_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign ent_tag    = rd_data[ENT_W-1 -: EPOCH_W];
  assign ent_key    = rd_data[KEY_W-1:0];
  assign slot_free  = ent_tag != epoch_r;
  assign key_hit    = ent_key == q_key;
  assign probe_last = cnt_r == LAST_SLOT;
  assign resolve    = slot_free || key_hit || probe_last;
  assign nxt_slot   = (cur_r == LAST_SLOT) ? '0 : cur_r + 1'b1;
  assign skip       = !in_data.finite || (kept_count_r >= lim_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign clr_last   = clr_r == LAST_SLOT;
  assign kc_ext     = 32'(kept_count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = skip ? ST_DONE : ST_HASH;
      end
      ST_HASH: begin
        if (q_done) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (resolve) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = (item_r.cloud_last && (epoch_r == EPOCH_MAX)) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    q_start  = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = cur_r;
    wr_en    = 1'b0;
    wr_addr  = cur_r;
    wr_data  = {epoch_r, q_key};
    load_out = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        q_start  = in_valid && !skip;
      end
      ST_HASH: begin
        rd_en   = q_done;
        rd_addr = q_slot;
      end
      ST_PROBE: begin
        rd_en   = !resolve;
        rd_addr = nxt_slot;
        wr_en   = slot_free;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  assign mk = cfg_data[KEPT_OUT_W-1:0];

  always_comb begin
    inv_wr = (cfg_data > INV_LEAF_MAX) ? INV_LEAF_MAX : cfg_data;
    if (mk == '0) begin
      lim_wr = KC_W'(1);
    end else if (32'(mk) > MAX_KEPT_LIMIT) begin
      lim_wr = KC_W'(MAX_KEPT_LIMIT);
    end else begin
      lim_wr = KC_W'(mk);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      epoch_r      <= EPOCH_ONE;
      kept_count_r <= '0;
      inv_leaf_r   <= INV_LEAF_RST;
      lim_r        <= LIM_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_INV_LEAF: inv_leaf_r <= inv_wr;
          CFG_MAX_KEPT: lim_r      <= lim_wr;
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_last ? '0 : clr_r + 1'b1;
      end
      if ((state_r == ST_PROBE) && slot_free) begin
        kept_count_r <= kept_count_r + 1'b1;
      end
      if (load_out && item_r.cloud_last) begin
        kept_count_r <= '0;
        epoch_r      <= (epoch_r == EPOCH_MAX) ? EPOCH_ONE : epoch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      item_r <= in_data;
      keep_r <= 1'b0;
      full_r <= 1'b0;
    end
    if ((state_r == ST_HASH) && q_done) begin
      cur_r <= q_slot;
      cnt_r <= '0;
    end
    if (state_r == ST_PROBE) begin
      if (slot_free) begin
        keep_r <= 1'b1;
      end else if (!key_hit && probe_last) begin
        full_r <= 1'b1;
      end else if (!resolve) begin
        cur_r <= nxt_slot;
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (load_out) begin
      out_data_r.keep        <= keep_r;
      out_data_r.out_x       <= item_r.pos_x;
      out_data_r.out_y       <= item_r.pos_y;
      out_data_r.out_z       <= item_r.pos_z;
      out_data_r.kept_so_far <= kc_ext[KEPT_OUT_W-1:0];
      out_data_r.table_full  <= full_r;
      out_data_r.cloud_end   <= item_r.cloud_last;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
